// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/dgso_pkg.sv
// types and constants of the dual glide sine oscillator
package dgso_pkg;

   // digit-serial multiplier geometry: 2 bits of b per cycle
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = 18;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_DIGITS = MUL_B_W / 2;
   localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

   localparam int CSR_ADDR_W = 4;

   localparam logic [MUL_B_W-1:0] STEP_PER_HZ = 18'd97392;
   localparam logic [MUL_B_W-1:0] GLIDE_KEEP  = 18'd62259;
   localparam logic [MUL_B_W-1:0] GLIDE_TAKE  = 18'd3277;
   localparam logic [MUL_B_W-1:0] SIN_C       = 18'd2320;
   localparam logic [15:0]        SIN_A       = 16'd51472;
   localparam logic [15:0]        SIN_B       = 16'd21024;
   localparam logic [14:0]        SAT_MAX     = 15'd32767;
   localparam logic [48:0]        ROUND_HALF  = 49'd32768;
   localparam logic [8:0]         GAIN_UNITY  = 9'd256;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_SET_LEFT  = 2'd1,
      CMD_SET_RIGHT = 2'd2,
      CMD_SILENCE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_VOLUME      = 2'd0,
      REG_LEFT_SCALE  = 2'd1,
      REG_RIGHT_SCALE = 2'd2
   } reg_index_type;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_TGT     = 11'b000_0000_0010,
      ST_GLIDE_A = 11'b000_0000_0100,
      ST_GLIDE_B = 11'b000_0000_1000,
      ST_PHASE   = 11'b000_0001_0000,
      ST_SQ      = 11'b000_0010_0000,
      ST_C       = 11'b000_0100_0000,
      ST_B       = 11'b000_1000_0000,
      ST_A       = 11'b001_0000_0000,
      ST_G       = 11'b010_0000_0000,
      ST_DONE    = 11'b100_0000_0000
   } seq_state_type;

   typedef struct packed {
      seq_state_type state;
      logic          go;
      logic          clear;
      logic          tgt_left;
      logic          tgt_right;
      logic [9:0]    value;
   } seq_ctrl_type;

endpackage

// File: rtl/dgso_serial_mul.sv
// digit-serial unsigned multiplier, two multiplier bits per cycle
module dgso_serial_mul
   import dgso_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic               done,
   output logic [MUL_P_W-1:0] prod
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic [MUL_P_W-1:0]   acc_ff;
   logic [MUL_P_W-1:0]   a_sh_ff;
   logic [MUL_B_W-1:0]   b_sh_ff;
   logic [MUL_P_W-1:0]   pp;

   // partial product of the current two-bit digit
   assign pp = (b_sh_ff[0] ? a_sh_ff : '0) + (b_sh_ff[1] ? (a_sh_ff << 1) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_W'(MUL_DIGITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         a_sh_ff <= MUL_P_W'(a);
         b_sh_ff <= b;
      end else if (busy_ff) begin
         acc_ff  <= acc_ff + pp;
         a_sh_ff <= a_sh_ff << 2;
         b_sh_ff <= b_sh_ff >> 2;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// File: rtl/dgso_lane.sv
// one oscillator channel: phase, steps, glide and sine datapath
module dgso_lane
   import dgso_pkg::*;
#(
   parameter int SINE_INDEX_BITS = 10
)
(
   input  logic               clock,
   input  logic               reset,
   input  seq_ctrl_type       ctrl,
   input  logic               tgt_en,
   input  logic [3:0]         scale,
   input  logic [8:0]         gain,
   output logic               mul_done,
   output logic signed [15:0] sample
);

   logic [31:0]        phase_ff;
   logic [31:0]        step_ff;
   logic [31:0]        target_ff;
   logic [47:0]        gacc_ff;
   logic [15:0]        z2_ff;
   logic [15:0]        t_ff;
   logic [14:0]        mag_ff;
   logic [15:0]        sample_ff;

   logic [15:0]        ang;
   logic [14:0]        r_fold;
   logic [15:0]        z;
   logic [13:0]        vs;
   logic [MUL_A_W-1:0] a_op;
   logic [MUL_B_W-1:0] b_op;
   logic [MUL_P_W-1:0] prod;
   logic [48:0]        glide_sum;
   logic [15:0]        s16;
   logic [14:0]        omag;

   // angle from the top phase bits, folded into the first quadrant
   assign ang    = 16'(phase_ff[31 -: SINE_INDEX_BITS]) << (16 - SINE_INDEX_BITS);
   assign r_fold = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
   assign z      = {r_fold, 1'b0};
   assign vs     = 14'(ctrl.value) * 14'(scale);

   assign glide_sum = {1'b0, gacc_ff} + prod[48:0] + ROUND_HALF;
   assign s16       = prod[30:15];
   assign omag      = prod[22:8];

   always_comb begin
      a_op = '0;
      b_op = '0;
      case (ctrl.state)
         ST_TGT: begin
            a_op = MUL_A_W'(vs);
            b_op = STEP_PER_HZ;
         end
         ST_GLIDE_A: begin
            a_op = step_ff;
            b_op = GLIDE_KEEP;
         end
         ST_GLIDE_B: begin
            a_op = target_ff;
            b_op = GLIDE_TAKE;
         end
         ST_SQ: begin
            a_op = MUL_A_W'(z);
            b_op = MUL_B_W'(z);
         end
         ST_C: begin
            a_op = MUL_A_W'(z2_ff);
            b_op = SIN_C;
         end
         ST_B: begin
            a_op = MUL_A_W'(t_ff);
            b_op = MUL_B_W'(z2_ff);
         end
         ST_A: begin
            a_op = MUL_A_W'(t_ff);
            b_op = MUL_B_W'(z);
         end
         ST_G: begin
            a_op = MUL_A_W'(mag_ff);
            b_op = MUL_B_W'(gain);
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   dgso_serial_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (ctrl.go),
      .a     (a_op),
      .b     (b_op),
      .done  (mul_done),
      .prod  (prod)
   );

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         step_ff   <= '0;
         target_ff <= '0;
      end else begin
         if (ctrl.clear) begin
            target_ff <= '0;
         end else if (mul_done && ctrl.state == ST_TGT && tgt_en) begin
            target_ff <= prod[31:0];
         end
         if (mul_done && ctrl.state == ST_GLIDE_B) begin
            step_ff <= glide_sum[47:16];
         end
         if (ctrl.state == ST_PHASE) begin
            phase_ff <= phase_ff + step_ff;
         end
      end
   end

   // intermediate products
   always_ff @(posedge clock) begin
      if (mul_done) begin
         case (ctrl.state)
            ST_GLIDE_A: gacc_ff <= prod[47:0];
            ST_SQ:      z2_ff   <= prod[30:15];
            ST_C:       t_ff    <= SIN_B - prod[30:15];
            ST_B:       t_ff    <= SIN_A - prod[30:15];
            ST_A:       mag_ff  <= (s16 > 16'd32767) ? SAT_MAX : s16[14:0];
            ST_G:       sample_ff <= ang[15] ? (16'd0 - {1'b0, omag}) : {1'b0, omag};
            default:    gacc_ff <= gacc_ff;
         endcase
      end
   end

   assign sample = $signed(sample_ff);

endmodule

// File: rtl/dgso_seq.sv
// sequencer: steps both channels through target, glide, phase and sine
`include "assert_macros.svh"
module dgso_seq
   import dgso_pkg::*;
#(
   parameter int BUFFER_LEN = 512
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  cmd_type      cmd,
   input  logic [9:0]   value,
   input  logic         out_free,
   input  logic         mul_done,
   output seq_ctrl_type ctrl,
   output logic         ready,
   output logic         out_load
);

   localparam int TICK_W = (BUFFER_LEN > 1) ? $clog2(BUFFER_LEN) : 1;
   localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(BUFFER_LEN - 1);

   seq_state_type     state_ff, state_in;
   logic              go_ff, go_in;
   logic [TICK_W-1:0] tick_ff;
   cmd_type           cmd_ff;
   logic [9:0]        value_ff;
   logic              tick_zero;

   assign tick_zero = (tick_ff == '0);

   always_comb begin
      state_in = state_ff;
      go_in    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_TICK: begin
                     if (tick_zero) begin
                        state_in = ST_GLIDE_A;
                        go_in    = 1'b1;
                     end else begin
                        state_in = ST_PHASE;
                     end
                  end
                  CMD_SET_LEFT, CMD_SET_RIGHT: begin
                     state_in = ST_TGT;
                     go_in    = 1'b1;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_TGT: if (mul_done) state_in = ST_IDLE;
         ST_GLIDE_A: begin
            if (mul_done) begin
               state_in = ST_GLIDE_B;
               go_in    = 1'b1;
            end
         end
         ST_GLIDE_B: if (mul_done) state_in = ST_PHASE;
         ST_PHASE: begin
            state_in = ST_SQ;
            go_in    = 1'b1;
         end
         ST_SQ: begin
            if (mul_done) begin
               state_in = ST_C;
               go_in    = 1'b1;
            end
         end
         ST_C: begin
            if (mul_done) begin
               state_in = ST_B;
               go_in    = 1'b1;
            end
         end
         ST_B: begin
            if (mul_done) begin
               state_in = ST_A;
               go_in    = 1'b1;
            end
         end
         ST_A: begin
            if (mul_done) begin
               state_in = ST_G;
               go_in    = 1'b1;
            end
         end
         ST_G: if (mul_done) state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
               out_load = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
         tick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         if (accept && cmd == CMD_TICK) begin
            tick_ff <= (tick_ff == TICK_LAST) ? '0 : tick_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd;
         value_ff <= value;
      end
   end

   assign ready           = (state_ff == ST_IDLE);
   assign ctrl.state      = state_ff;
   assign ctrl.go         = go_ff;
   assign ctrl.clear      = accept && (cmd == CMD_SILENCE);
   assign ctrl.tgt_left   = (cmd_ff == CMD_SET_LEFT);
   assign ctrl.tgt_right  = (cmd_ff == CMD_SET_RIGHT);
   assign ctrl.value      = value_ff;

   `ASSERT_IMPLIES(a_done_in_mul_state, clock, reset, mul_done, (state_ff != ST_IDLE) && (state_ff != ST_PHASE) && (state_ff != ST_DONE))

endmodule

// File: rtl/dual_glide_sine_oscillator.sv
// top level of the dual glide sine oscillator
// stereo pair of sine oscillators with gliding frequency
//
// input channel req_: one beat carries a command in req_tuser and a control
// value in req_tdata. tick commands give one stereo beat on rsp_; target and
// silence commands give none. csr_ is an apb-style port for the volume and
// the two frequency scales (byte addresses 0, 4, 8).
//
// timing: each channel has its own digit-serial multiplier that retires two
// multiplier bits a cycle, and its products are sequenced one after another.
// a tick loads its result beat into the output register as the sequencer
// leaves its done state, and the next beat can be accepted once the sequencer
// is idle; the first tick of each buffer adds two glide products. a target
// command takes one product, and silence completes in its accept cycle.
//
// reset clears phases, steps, targets and the buffer counter and loads the
// register defaults. an output register holds a finished beat while the
// receiver stalls, and the next item can be accepted meanwhile; a second
// result waits in the sequencer until the output register frees
`include "assert_macros.svh"
module dual_glide_sine_oscillator
   import dgso_pkg::*;
#(
   parameter int BUFFER_LEN      = 512,
   parameter int SINE_INDEX_BITS = 10
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [9:0] value, [15:10] zero
   input  logic [1:0]            req_tuser,   // [1:0] cmd

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [15:0] left_sample, [31:16] right_sample

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic [8:0]         gain_ff;
   logic [3:0]         lscale_ff;
   logic [3:0]         rscale_ff;
   logic [8:0]         gain_eff;
   logic               csr_wr;

   // sequencer and channel links
   seq_ctrl_type       ctrl;
   logic               accept;
   logic               out_load;
   logic               out_free;
   logic               left_done;
   logic               right_done;
   logic signed [15:0] left_sample;
   logic signed [15:0] right_sample;

   // output register
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= 9'd77;
         lscale_ff <= 4'd8;
         rscale_ff <= 4'd3;
      end else if (csr_wr) begin
         case (csr_paddr[CSR_ADDR_W-1:2])
            REG_VOLUME:      gain_ff   <= csr_pwdata[8:0];
            REG_LEFT_SCALE:  lscale_ff <= csr_pwdata[3:0];
            REG_RIGHT_SCALE: rscale_ff <= csr_pwdata[3:0];
            default:         gain_ff   <= gain_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_ADDR_W-1:2])
         REG_VOLUME:      csr_prdata = 32'(gain_ff);
         REG_LEFT_SCALE:  csr_prdata = 32'(lscale_ff);
         REG_RIGHT_SCALE: csr_prdata = 32'(rscale_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // gain above unity acts as unity
   assign gain_eff = (gain_ff > GAIN_UNITY) ? GAIN_UNITY : gain_ff;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   dgso_seq #(
      .BUFFER_LEN (BUFFER_LEN)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cmd      (cmd_type'(req_tuser)),
      .value    (req_tdata[9:0]),
      .out_free (out_free),
      .mul_done (left_done && right_done),
      .ctrl     (ctrl),
      .ready    (req_tready),
      .out_load (out_load)
   );

   dgso_lane #(
      .SINE_INDEX_BITS (SINE_INDEX_BITS)
   ) u_left (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .tgt_en   (ctrl.tgt_left),
      .scale    (lscale_ff),
      .gain     (gain_eff),
      .mul_done (left_done),
      .sample   (left_sample)
   );

   dgso_lane #(
      .SINE_INDEX_BITS (SINE_INDEX_BITS)
   ) u_right (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .tgt_en   (ctrl.tgt_right),
      .scale    (rscale_ff),
      .gain     (gain_eff),
      .mul_done (right_done),
      .sample   (right_sample)
   );

   // result beat register, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {right_sample, left_sample};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // silence is done in its accept cycle, so only the other commands keep the input busy
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready && (req_tuser != CMD_SILENCE), !req_tready)
   `ASSERT_NEXT(a_no_beat_for_control, clock, reset, req_tvalid && req_tready && (req_tuser != CMD_TICK) && !rsp_tvalid, !rsp_tvalid)

endmodule
